/* rtl/core/yss_pkg.sv */
// Types and constants shared by the yaw scan sequencer.
package yss_pkg;

  localparam int unsigned PosW     = 21;
  localparam int unsigned VelW     = 18;
  localparam int unsigned AngW     = 16;
  localparam int unsigned DtW      = 16;
  localparam int unsigned RateW    = 17;
  localparam int unsigned LimW     = 16;
  localparam int unsigned WinW     = 15;
  localparam int unsigned TurnW    = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 88;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpinRate      = 3'd0,
    CfgPauseDist     = 3'd1,
    CfgResumeDist    = 3'd2,
    CfgCriticalDist  = 3'd3,
    CfgPauseSpeed    = 3'd4,
    CfgResumeSpeed   = 3'd5,
    CfgCriticalHeight = 3'd6,
    CfgYawWindow     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StatusRun  = 2'd0,
    StatusDone = 2'd1,
    StatusFail = 2'd2
  } status_e;

  typedef enum logic {
    FuncEnter = 1'b0,
    FuncTick  = 1'b1
  } func_e;

  // Register defaults; distance and speed limits are kept squared.
  localparam logic [RateW-1:0]  SpinRateRst       = 17'd5215;
  localparam logic [2*LimW-1:0] PauseDistSqRst    = 32'd62500;
  localparam logic [2*LimW-1:0] ResumeDistSqRst   = 32'd14400;
  localparam logic [2*LimW-1:0] CriticalDistSqRst = 32'd360000;
  localparam logic [2*LimW-1:0] PauseSpeedSqRst   = 32'd122500;
  localparam logic [2*LimW-1:0] ResumeSpeedSqRst  = 32'd22500;
  localparam logic [LimW-1:0]   CriticalHeightRst = 16'd400;
  localparam logic [WinW-1:0]   YawWindowRst      = 15'd1456;

  // Packed so that the last field lands in the lowest bits.
  typedef struct packed {
    logic [2:0]              pad;
    logic                    sample_done;
    logic                    target_seen;
    logic [DtW-1:0]          tick_time;
    logic [AngW-1:0]         heading;
    logic signed [VelW-1:0]  vel_y;
    logic signed [VelW-1:0]  vel_x;
    logic signed [PosW-1:0]  pos_z;
    logic signed [PosW-1:0]  pos_y;
    logic signed [PosW-1:0]  pos_x;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              pad;
    logic                    land_request;
    logic                    clear_vision_flags;
    logic                    searching;
    logic                    vision_on;
    logic                    front_camera_on;
    logic [AngW-1:0]         yaw_setpoint;
    logic signed [PosW-1:0]  hold_sp_z;
    logic signed [PosW-1:0]  hold_sp_y;
    logic signed [PosW-1:0]  hold_sp_x;
    logic [1:0]              status;
  } out_item_t;

  // Magnitude of the wrapped difference a - b; a half turn reads as 32768.
  function automatic logic [AngW-1:0] angle_mag(input logic [AngW-1:0] a,
                                                input logic [AngW-1:0] b);
    logic [AngW-1:0] d;
    d = a - b;
    return d[AngW-1] ? (~d + 1'b1) : d;
  endfunction

endpackage

/* rtl/core/yaw_scan_sequencer.sv */
// Yaw scan sequencer: hold point, yaw spin, drift pause and abort, vision stop.
// Each item passes through the input register and then the output register.
// Throughput: one item per cycle unless the output stalls; the combinational step
// between the input register and the output register also updates the sequencer state.
// Reset clears all state and valids and loads the register defaults.
// The config port is always ready; squared limits are formed on the write.
module yaw_scan_sequencer
  import yss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, heading, tick_time, target_seen,
  // sample_done, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // func
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status, hold_sp_x, hold_sp_y, hold_sp_z, yaw_setpoint, front_camera_on,
  // vision_on, searching, clear_vision_flags, land_request, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Config registers
  logic [RateW-1:0]  spin_rate_q;
  logic [2*LimW-1:0] pause_dist_sq_q, resume_dist_sq_q, crit_dist_sq_q;
  logic [2*LimW-1:0] pause_speed_sq_q, resume_speed_sq_q;
  logic [LimW-1:0]   crit_height_q;
  logic [WinW-1:0]   yaw_window_q;
  logic [2*LimW-1:0] cfg_sq;

  assign cfg_ready_o = 1'b1;
  assign cfg_sq = cfg_data_i[LimW-1:0] * cfg_data_i[LimW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_rate_q       <= SpinRateRst;
      pause_dist_sq_q   <= PauseDistSqRst;
      resume_dist_sq_q  <= ResumeDistSqRst;
      crit_dist_sq_q    <= CriticalDistSqRst;
      pause_speed_sq_q  <= PauseSpeedSqRst;
      resume_speed_sq_q <= ResumeSpeedSqRst;
      crit_height_q     <= CriticalHeightRst;
      yaw_window_q      <= YawWindowRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgSpinRate:       spin_rate_q       <= cfg_data_i[RateW-1:0];
        CfgPauseDist:      pause_dist_sq_q   <= cfg_sq;
        CfgResumeDist:     resume_dist_sq_q  <= cfg_sq;
        CfgCriticalDist:   crit_dist_sq_q    <= cfg_sq;
        CfgPauseSpeed:     pause_speed_sq_q  <= cfg_sq;
        CfgResumeSpeed:    resume_speed_sq_q <= cfg_sq;
        CfgCriticalHeight: crit_height_q     <= cfg_data_i[LimW-1:0];
        CfgYawWindow:      yaw_window_q      <= cfg_data_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  // Input register and output register
  logic      in_valid_q, out_valid_q;
  in_item_t  in_q;
  logic      in_func_q;
  out_item_t out_q, out_d;
  logic      advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q      <= in_item_t'(s_axis_tdata);
      in_func_q <= s_axis_tuser;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Sequencer state
  logic                   stab_q, stab_d;
  logic [AngW-1:0]        target_q, target_d;
  logic [AngW-1:0]        prev_q, prev_d;
  logic [TurnW-1:0]       turned_q, turned_d;
  logic signed [PosW-1:0] hold_x_q, hold_y_q, hold_z_q;
  logic signed [PosW-1:0] hold_x_d, hold_y_d, hold_z_d;
  logic                   front_q, front_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stab_q   <= 1'b0;
      target_q <= '0;
      prev_q   <= '0;
      turned_q <= '0;
      hold_x_q <= '0;
      hold_y_q <= '0;
      hold_z_q <= '0;
      front_q  <= 1'b0;
    end else if (advance) begin
      stab_q   <= stab_d;
      target_q <= target_d;
      prev_q   <= prev_d;
      turned_q <= turned_d;
      hold_x_q <= hold_x_d;
      hold_y_q <= hold_y_d;
      hold_z_q <= hold_z_d;
      front_q  <= front_d;
    end
  end

  // Drift and speed, compared as squares
  logic signed [PosW:0]   ex, ey, ez;
  logic [PosW:0]          ex_mag, ey_mag, ez_mag;
  logic [2*PosW+1:0]      ex_sq, ey_sq;
  logic [2*PosW+2:0]      exy2;
  logic [VelW-1:0]        vx_mag, vy_mag;
  logic [2*VelW-1:0]      vx_sq, vy_sq;
  logic [2*VelW:0]        vxy2;
  logic                   critical, pause, recov;

  assign ex = {in_q.pos_x[PosW-1], in_q.pos_x} - {hold_x_q[PosW-1], hold_x_q};
  assign ey = {in_q.pos_y[PosW-1], in_q.pos_y} - {hold_y_q[PosW-1], hold_y_q};
  assign ez = {in_q.pos_z[PosW-1], in_q.pos_z} - {hold_z_q[PosW-1], hold_z_q};
  // Most negative values wrap to the correct unsigned magnitude.
  assign ex_mag = ex[PosW] ? (~ex + 1'b1) : ex;
  assign ey_mag = ey[PosW] ? (~ey + 1'b1) : ey;
  assign ez_mag = ez[PosW] ? (~ez + 1'b1) : ez;
  assign vx_mag = in_q.vel_x[VelW-1] ? (~in_q.vel_x + 1'b1) : in_q.vel_x;
  assign vy_mag = in_q.vel_y[VelW-1] ? (~in_q.vel_y + 1'b1) : in_q.vel_y;
  assign ex_sq  = ex_mag * ex_mag;
  assign ey_sq  = ey_mag * ey_mag;
  assign vx_sq  = vx_mag * vx_mag;
  assign vy_sq  = vy_mag * vy_mag;
  assign exy2   = {1'b0, ex_sq} + {1'b0, ey_sq};
  assign vxy2   = {1'b0, vx_sq} + {1'b0, vy_sq};

  assign critical = (exy2 > {13'd0, crit_dist_sq_q}) ||
                    (ez_mag > {6'd0, crit_height_q});
  assign pause    = (exy2 > {13'd0, pause_dist_sq_q}) ||
                    (vxy2 > {5'd0, pause_speed_sq_q});
  assign recov    = (exy2 < {13'd0, resume_dist_sq_q}) &&
                    (vxy2 < {5'd0, resume_speed_sq_q});

  // Turn accumulator, saturating
  logic [TurnW:0]   turn_sum;
  logic [TurnW-1:0] turned_new;

  assign turn_sum   = {1'b0, turned_q} + {2'b0, angle_mag(in_q.heading, prev_q)};
  assign turned_new = turn_sum[TurnW] ? '1 : turn_sum[TurnW-1:0];

  // Yaw step: spin_rate * dt / 65536, rounded half up
  logic signed [RateW+DtW-1:0] prod;
  logic [RateW+DtW:0]          rnd;
  logic                        in_window;

  assign prod = $signed(spin_rate_q) * $signed({1'b0, in_q.tick_time});
  assign rnd  = {prod[RateW+DtW-1], prod} + (RateW+DtW+1)'(32768);
  assign in_window = {1'b0, angle_mag(target_q, in_q.heading)} < {2'b0, yaw_window_q};

  always_comb begin
    status_e st;
    logic    vis, clr, land;

    stab_d   = stab_q;
    target_d = target_q;
    prev_d   = prev_q;
    turned_d = turned_q;
    hold_x_d = hold_x_q;
    hold_y_d = hold_y_q;
    hold_z_d = hold_z_q;
    front_d  = front_q;
    st       = StatusRun;
    vis      = 1'b1;
    clr      = 1'b0;
    land     = 1'b0;

    if (func_e'(in_func_q) == FuncEnter) begin
      hold_x_d = in_q.pos_x;
      hold_y_d = in_q.pos_y;
      hold_z_d = in_q.pos_z;
      target_d = in_q.heading;
      prev_d   = in_q.heading;
      turned_d = '0;
      stab_d   = 1'b0;
      front_d  = 1'b1;
      clr      = 1'b1;
    end else if (critical) begin
      st      = StatusFail;
      land    = 1'b1;
      clr     = 1'b1;
      vis     = 1'b0;
      front_d = 1'b0;
    end else begin
      turned_d = turned_new;
      prev_d   = in_q.heading;
      if (pause && !recov) begin
        target_d = in_q.heading;
      end else begin
        if (!stab_q) begin
          front_d = 1'b1;
          if (in_window) begin
            target_d = target_q + rnd[AngW+15:16];
          end
          if (in_q.target_seen) begin
            stab_d   = 1'b1;
            target_d = in_q.heading;
            front_d  = 1'b0;
          end
        end else if (in_q.sample_done) begin
          clr      = 1'b1;
          target_d = in_q.heading;
          front_d  = 1'b1;
          stab_d   = 1'b0;
        end
        // a full turn is 65536 units
        if (turned_new[TurnW-1]) begin
          st      = StatusDone;
          vis     = 1'b0;
          clr     = 1'b1;
          front_d = 1'b0;
        end
      end
    end

    out_d                    = '0;
    out_d.status             = st;
    out_d.hold_sp_x          = hold_x_d;
    out_d.hold_sp_y          = hold_y_d;
    out_d.hold_sp_z          = hold_z_d;
    out_d.yaw_setpoint       = target_d;
    out_d.front_camera_on    = front_d;
    out_d.vision_on          = vis;
    out_d.searching          = vis;
    out_d.clear_vision_flags = clr;
    out_d.land_request       = land;
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the yaw scan sequencer: scan sequences, drift cases, settings sweep.
module tb_top;
  import yss_pkg::*;

  localparam int CycleLimit   = 1000000;
  localparam int ItemTarget   = 1760;
  localparam int PrintCap     = 100;
  localparam int PosMax       = 1000000;
  localparam int VelMax       = 100000;
  localparam int TurnSat      = 131071;
  localparam int FullTurn     = 65536;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  yaw_scan_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Scan model: settings and sequencer state.
  logic signed [RateW-1:0] spin_rate;
  logic [LimW-1:0] pause_dist, resume_dist, critical_dist;
  logic [LimW-1:0] pause_speed, resume_speed, critical_height;
  logic [WinW-1:0] yaw_window;

  logic            stabilizing;
  logic [AngW-1:0] yaw_target;
  logic [AngW-1:0] last_heading;
  int              turn_sum;
  int              hold_x, hold_y, hold_z;
  logic            front_cam;

  out_item_t expected_results[$];
  int        items_sent;
  int        results_seen;
  int        mismatches;
  int        cycle_count;
  bit        steady_src;
  bit        steady_sink;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic int rnd(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp(input int v, input int lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  // Idle stretch length: mostly short, now and then long.
  function automatic int idle_len();
    return ($urandom_range(9) == 0) ? rnd(10, 40) : rnd(1, 3);
  endfunction

  // Wrapped heading difference magnitude, half turn reads as 32768.
  function automatic int yaw_delta_mag(input logic [AngW-1:0] a, input logic [AngW-1:0] b);
    logic [AngW-1:0] d;
    d = a - b;
    return (d >= 16'd32768) ? (FullTurn - int'(d)) : int'(d);
  endfunction

  function automatic longint sq_lim(input logic [LimW-1:0] v);
    return longint'(v) * longint'(v);
  endfunction

  function automatic void reset_scan_model();
    spin_rate       = 17'sd5215;
    pause_dist      = 16'd250;
    resume_dist     = 16'd120;
    critical_dist   = 16'd600;
    pause_speed     = 16'd350;
    resume_speed    = 16'd150;
    critical_height = 16'd400;
    yaw_window      = 15'd1456;
    stabilizing     = 1'b0;
    yaw_target      = '0;
    last_heading    = '0;
    turn_sum        = 0;
    hold_x          = 0;
    hold_y          = 0;
    hold_z          = 0;
    front_cam       = 1'b0;
  endfunction

  // One sequencer step: updates the model state and returns the result item.
  function automatic out_item_t scan_step(input func_e f, input in_item_t it);
    out_item_t r;
    longint    ex, ey, ez, ezm, exy2, vxy2, p, stp;
    logic      do_pause, do_recov;
    r = '0;
    r.status    = StatusRun;
    r.vision_on = 1'b1;
    r.searching = 1'b1;
    if (f == FuncEnter) begin
      hold_x       = int'($signed(it.pos_x));
      hold_y       = int'($signed(it.pos_y));
      hold_z       = int'($signed(it.pos_z));
      yaw_target   = it.heading;
      last_heading = it.heading;
      turn_sum     = 0;
      stabilizing  = 1'b0;
      front_cam    = 1'b1;
      r.clear_vision_flags = 1'b1;
    end else begin
      ex   = longint'($signed(it.pos_x)) - hold_x;
      ey   = longint'($signed(it.pos_y)) - hold_y;
      ez   = longint'($signed(it.pos_z)) - hold_z;
      ezm  = (ez < 0) ? -ez : ez;
      exy2 = ex * ex + ey * ey;
      vxy2 = longint'($signed(it.vel_x)) * longint'($signed(it.vel_x)) +
             longint'($signed(it.vel_y)) * longint'($signed(it.vel_y));
      if (exy2 > sq_lim(critical_dist) || ezm > longint'(critical_height)) begin
        r.status             = StatusFail;
        r.land_request       = 1'b1;
        r.clear_vision_flags = 1'b1;
        r.vision_on          = 1'b0;
        r.searching          = 1'b0;
        front_cam            = 1'b0;
      end else begin
        do_pause = (exy2 > sq_lim(pause_dist)) || (vxy2 > sq_lim(pause_speed));
        do_recov = (exy2 < sq_lim(resume_dist)) && (vxy2 < sq_lim(resume_speed));
        turn_sum += yaw_delta_mag(it.heading, last_heading);
        if (turn_sum > TurnSat) turn_sum = TurnSat;
        last_heading = it.heading;
        if (do_pause && !do_recov) begin
          yaw_target = it.heading;
        end else begin
          if (!stabilizing) begin
            front_cam = 1'b1;
            if (yaw_delta_mag(yaw_target, it.heading) < int'(yaw_window)) begin
              // round to nearest, ties toward plus infinity
              p   = longint'(spin_rate) * longint'(it.tick_time);
              stp = (p + 64'sd32768) >>> 16;
              yaw_target = yaw_target + stp[AngW-1:0];
            end
            if (it.target_seen) begin
              stabilizing = 1'b1;
              yaw_target  = it.heading;
              front_cam   = 1'b0;
            end
          end else if (it.sample_done) begin
            r.clear_vision_flags = 1'b1;
            yaw_target  = it.heading;
            front_cam   = 1'b1;
            stabilizing = 1'b0;
          end
          if (turn_sum >= FullTurn) begin
            r.status             = StatusDone;
            r.vision_on          = 1'b0;
            r.searching          = 1'b0;
            r.clear_vision_flags = 1'b1;
            front_cam            = 1'b0;
          end
        end
      end
    end
    r.hold_sp_x       = hold_x[PosW-1:0];
    r.hold_sp_y       = hold_y[PosW-1:0];
    r.hold_sp_z       = hold_z[PosW-1:0];
    r.yaw_setpoint    = yaw_target;
    r.front_camera_on = front_cam;
    return r;
  endfunction

  function automatic in_item_t mk_item(input int x, input int y, input int z, input int vx,
                                       input int vy, input int hd, input int dt,
                                       input bit seen, input bit done);
    in_item_t it;
    it = '0;
    it.pos_x       = x[PosW-1:0];
    it.pos_y       = y[PosW-1:0];
    it.pos_z       = z[PosW-1:0];
    it.vel_x       = vx[VelW-1:0];
    it.vel_y       = vy[VelW-1:0];
    it.heading     = hd[AngW-1:0];
    it.tick_time   = dt[DtW-1:0];
    it.target_seen = seen;
    it.sample_done = done;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    return mk_item(rnd(-PosMax, PosMax), rnd(-PosMax, PosMax), rnd(-PosMax, PosMax),
                   rnd(-VelMax, VelMax), rnd(-VelMax, VelMax), rnd(0, 65535),
                   rnd(0, 65535), $urandom_range(1), $urandom_range(1));
  endfunction

  function automatic in_item_t enter_item();
    int lim;
    lim = ($urandom_range(4) == 0) ? PosMax : 900000;
    return mk_item(rnd(-lim, lim), rnd(-lim, lim), rnd(-lim, lim),
                   rnd(-VelMax, VelMax), rnd(-VelMax, VelMax), rnd(0, 65535),
                   rnd(0, 65535), $urandom_range(1), $urandom_range(1));
  endfunction

  // Tick mostly near the hold point, with the heading mostly following the yaw setpoint.
  function automatic in_item_t scan_tick();
    int r, sxy, sv, sz, hd, dt, win;
    bit seen, done;
    r = $urandom_range(99);
    if (r < 70) begin
      sxy = resume_dist / 2;
      sv  = resume_speed / 2;
      sz  = critical_height;
    end else if (r < 94) begin
      sxy = 2 * pause_dist;
      sv  = 2 * pause_speed;
      sz  = critical_height;
    end else begin
      sxy = 2 * critical_dist + 2;
      sv  = VelMax;
      sz  = 2 * critical_height + 2;
    end
    if (sv > VelMax) sv = VelMax;
    win = (yaw_window > 15'd4000) ? 2000 : int'(yaw_window) / 2;
    r = $urandom_range(99);
    if (r < 80) hd = int'(yaw_target) + rnd(-win, win);
    else if (r < 95) hd = rnd(0, 65535);
    else hd = int'(last_heading) + 32768;
    r = $urandom_range(99);
    if (r < 70) dt = rnd(2000, 20000);
    else if (r < 95) dt = rnd(0, 65535);
    else dt = $urandom_range(1) ? 65535 : 0;
    seen = stabilizing ? $urandom_range(1) : ($urandom_range(24) == 0);
    done = stabilizing ? ($urandom_range(9) < 4) : ($urandom_range(4) == 0);
    return mk_item(clamp(hold_x + rnd(-sxy, sxy), PosMax), clamp(hold_y + rnd(-sxy, sxy), PosMax),
                   clamp(hold_z + rnd(-sz, sz), PosMax), rnd(-sv, sv), rnd(-sv, sv),
                   hd, dt, seen, done);
  endfunction

  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    if (mismatches < PrintCap)
      $display("[%0t] result %0d: %s got %0d expected %0d", $time, results_seen, what,
               got_v, want_v);
    mismatches++;
  endtask

  task automatic send_item(input func_e f, input in_item_t it);
    int gap;
    gap = (steady_src || $urandom_range(9) < 7) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(scan_step(f, it));
    items_sent++;
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgSpinRate:       spin_rate       = val;
      CfgPauseDist:      pause_dist      = val[LimW-1:0];
      CfgResumeDist:     resume_dist     = val[LimW-1:0];
      CfgCriticalDist:   critical_dist   = val[LimW-1:0];
      CfgPauseSpeed:     pause_speed     = val[LimW-1:0];
      CfgResumeSpeed:    resume_speed    = val[LimW-1:0];
      CfgCriticalHeight: critical_height = val[LimW-1:0];
      CfgYawWindow:      yaw_window      = val[WinW-1:0];
      default: ;
    endcase
  endtask

  // Writes all eight registers back to back, only once the block is idle.
  task automatic apply_settings(input int rate, input int pd, input int rd, input int cd,
                                input int ps, input int rs, input int ch, input int win);
    wait_results_done();
    write_reg(CfgSpinRate, rate[CfgDataW-1:0]);
    write_reg(CfgPauseDist, {1'b0, pd[LimW-1:0]});
    write_reg(CfgResumeDist, {1'b0, rd[LimW-1:0]});
    write_reg(CfgCriticalDist, {1'b0, cd[LimW-1:0]});
    write_reg(CfgPauseSpeed, {1'b0, ps[LimW-1:0]});
    write_reg(CfgResumeSpeed, {1'b0, rs[LimW-1:0]});
    write_reg(CfgCriticalHeight, {1'b0, ch[LimW-1:0]});
    write_reg(CfgYawWindow, {2'b0, win[WinW-1:0]});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_random_settings();
    int pd, ps;
    pd = rnd(50, 2000);
    ps = rnd(50, 2000);
    apply_settings(rnd(-65535, 65535), pd, ($urandom_range(4) == 0) ? rnd(0, 3000) : rnd(0, pd),
                   rnd(pd, 4000), ps, ($urandom_range(4) == 0) ? rnd(0, 3000) : rnd(0, ps),
                   rnd(100, 2000), rnd(200, 32767));
  endtask

  task automatic run_scan(input int max_ticks);
    int k;
    send_item(FuncEnter, enter_item());
    for (k = 0; k < max_ticks; k++) begin
      send_item(FuncTick, scan_tick());
      if (turn_sum >= FullTurn && $urandom_range(3) == 0) break;
    end
  endtask

  task automatic test_directed();
    int k, h;
    steady_src  = 1'b0;
    steady_sink = 1'b0;
    // tick with state still at reset
    send_item(FuncTick, mk_item(0, 0, 0, 0, 0, 0, 65535, 0, 0));
    send_item(FuncEnter, mk_item(PosMax, -PosMax, PosMax, VelMax, -VelMax, 65535, 0, 1, 1));
    send_item(FuncTick, mk_item(-PosMax, PosMax, -PosMax, -VelMax, VelMax, 0, 65535, 1, 1));
    send_item(FuncEnter, mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // height exactly on the limit; dt gives a half-unit step
    send_item(FuncTick, mk_item(0, 0, 400, 0, 0, 100, 32768, 0, 0));
    send_item(FuncTick, mk_item(0, 0, 401, 0, 0, 300, 1000, 0, 0));
    send_item(FuncTick, mk_item(600, 0, 0, 0, 0, 200, 1000, 0, 0));
    send_item(FuncTick, mk_item(600, 1, 0, 0, 0, 400, 1000, 0, 0));
    send_item(FuncTick, mk_item(0, 250, 0, 0, 0, 300, 1000, 0, 0));
    send_item(FuncTick, mk_item(-251, 0, 0, 0, 0, 400, 1000, 0, 0));
    send_item(FuncTick, mk_item(0, 0, 0, 350, 0, 500, 1000, 0, 0));
    send_item(FuncTick, mk_item(0, 0, 0, 0, -351, 600, 1000, 0, 0));
    // detection, wait for sampling, resume
    send_item(FuncTick, mk_item(0, 0, 0, 0, 0, yaw_target, 8000, 1, 0));
    send_item(FuncTick, mk_item(0, 0, 0, 0, 0, yaw_target + 5, 8000, 1, 0));
    send_item(FuncTick, mk_item(0, 0, 0, 0, 0, yaw_target, 8000, 0, 1));
    // half-turn jumps: full turn, then accumulator saturation
    h = last_heading;
    for (k = 0; k < 5; k++)
      send_item(FuncTick, mk_item(0, 0, 0, 0, 0, h + ((k % 2 == 0) ? 32768 : 0), 4000, 0, 0));
    send_item(FuncEnter, mk_item(-PosMax, PosMax, -PosMax, 0, 0, 32768, 0, 0, 0));
    send_item(FuncTick, mk_item(-PosMax, PosMax, -PosMax, -VelMax, -VelMax, 32768, 9000, 0, 0));
    send_item(FuncTick, mk_item(-PosMax, PosMax, -PosMax, 0, 0, 32768, 0, 0, 0));
  endtask

  task automatic test_settings_sweep();
    int k;
    apply_settings(65535, 65535, 65535, 65535, 65535, 65535, 65535, 32767);
    run_scan(40);
    apply_settings(-65535, 0, 0, 0, 0, 0, 0, 0);
    run_scan(20);
    // resume limits above pause limits: drift can pause and recover at once
    apply_settings(-5215, 200, 500, 900, 100, 400, 600, 3000);
    send_item(FuncEnter, mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(FuncTick, mk_item(0, 0, 0, 0, 0, 0, 32768, 0, 0));
    send_item(FuncTick, mk_item(300, 0, 0, 200, 0, yaw_target, 4000, 0, 0));
    run_scan(40);
    steady_src  = 1'b1;
    steady_sink = 1'b1;
    for (k = 0; k < 3; k++) begin
      apply_random_settings();
      run_scan(50);
      steady_src  = 1'b0;
      steady_sink = 1'b0;
    end
    apply_settings(5215, 250, 120, 600, 350, 150, 400, 1456);
  endtask

  task automatic test_random_scans();
    int last_cfg, k, n;
    last_cfg = items_sent;
    while (items_sent < ItemTarget) begin
      steady_src  = ($urandom_range(4) == 0);
      steady_sink = ($urandom_range(4) == 0);
      if ($urandom_range(9) == 0) begin
        n = rnd(1, 5);
        for (k = 0; k < n; k++) send_item(func_e'($urandom_range(1)), noise_item());
      end else begin
        run_scan(rnd(10, 90));
      end
      if (items_sent - last_cfg > 400) begin
        apply_random_settings();
        last_cfg = items_sent;
      end
    end
  endtask

  // Result side: random backpressure and field-by-field check.
  initial begin
    int        stall_left;
    out_item_t got, want;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.hold_sp_x !== want.hold_sp_x)
            report_mismatch("hold_sp_x", got.hold_sp_x, want.hold_sp_x);
          if (got.hold_sp_y !== want.hold_sp_y)
            report_mismatch("hold_sp_y", got.hold_sp_y, want.hold_sp_y);
          if (got.hold_sp_z !== want.hold_sp_z)
            report_mismatch("hold_sp_z", got.hold_sp_z, want.hold_sp_z);
          if (got.yaw_setpoint !== want.yaw_setpoint)
            report_mismatch("yaw_setpoint", got.yaw_setpoint, want.yaw_setpoint);
          if (got.front_camera_on !== want.front_camera_on)
            report_mismatch("front_camera_on", got.front_camera_on, want.front_camera_on);
          if (got.vision_on !== want.vision_on)
            report_mismatch("vision_on", got.vision_on, want.vision_on);
          if (got.searching !== want.searching)
            report_mismatch("searching", got.searching, want.searching);
          if (got.clear_vision_flags !== want.clear_vision_flags)
            report_mismatch("clear_vision_flags", got.clear_vision_flags,
                            want.clear_vision_flags);
          if (got.land_request !== want.land_request)
            report_mismatch("land_request", got.land_request, want.land_request);
        end
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady_sink && $urandom_range(99) < 12) stall_left = idle_len();
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FuncEnter;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgSpinRate;
    cfg_data_i    = '0;
    steady_src    = 1'b0;
    steady_sink   = 1'b0;
    items_sent    = 0;
    results_seen  = 0;
    mismatches    = 0;
    reset_scan_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings_sweep();
    test_random_scans();
    wait_results_done();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
